// ===== rtl/rmth_pkg.sv =====
// ----------------------------------------------------------------------------
// rmth_pkg
// Types, widths and the heap order compare for the two-heap running median.
// ----------------------------------------------------------------------------
package rmth_pkg;

   localparam int SAMPLE_W = 32;
   localparam int MEDIAN_W = 33;
   localparam int COUNT_W  = 11;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [MEDIAN_W-1:0] median_type;
   typedef logic [COUNT_W-1:0]         count_type;

   // max-heap order when is_max, else min-heap order
   function automatic logic precedes(input sample_type a, input sample_type b,
                                     input logic is_max);
      precedes = is_max ? (a > b) : (a < b);
   endfunction

endpackage

// ===== rtl/rmth_ram.sv =====
// ----------------------------------------------------------------------------
// rmth_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rmth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/running_median_two_heaps_top.sv =====
// ----------------------------------------------------------------------------
// running_median_two_heaps_top
// Running median over a stream of signed samples, kept in a max-heap of the
// lower half and a min-heap of the upper half, each in its own RAM.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req      | in        | req_valid, req_stall | req_sample
//  rsp      | out       | rsp_valid, rsp_stall | rsp_median_doubled,
//           |           |                      | rsp_sample_count, rsp_rejected
//
//  each level of sift up passes S_UP_P and S_UP_C, and each level of sift
//  down S_DN_L, S_DN_R and S_DN_C, reading through the shared RAM read port
//  reset clears state, heap sizes, rsp_valid, push_after; heap RAMs never cleared
//  a new item is taken while the previous result waits on rsp_stall
//  a full pair of heaps rejects the item, going from S_IDLE to S_DONE
module running_median_two_heaps_top #(
   parameter int HEAP_DEPTH = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [31:0]            req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [32:0]            rsp_median_doubled,
   output logic [10:0]                   rsp_sample_count,
   output logic                          rsp_rejected
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int SW = $clog2(HEAP_DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DN_L = 3'd1;
   localparam logic [2:0] S_DN_R = 3'd2;
   localparam logic [2:0] S_DN_C = 3'd3;
   localparam logic [2:0] S_UP_P = 3'd4;
   localparam logic [2:0] S_UP_C = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic                   sel_ff, sel_in;          // 1 selects upper heap
   rmth_pkg::sample_type   val_ff, val_in;
   rmth_pkg::sample_type   mov_ff, mov_in;
   logic                   push_after_ff, push_after_in;
   logic [AW-1:0]          idx_ff, idx_in;
   rmth_pkg::sample_type   lval_ff, lval_in;
   logic                   rok_ff, rok_in;
   logic [SW-1:0]          ls_ff, ls_in, us_ff, us_in;
   rmth_pkg::sample_type   ltop_ff, ltop_in, utop_ff, utop_in;
   logic                   rej_ff, rej_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rmth_pkg::median_type   med_ff, med_in;
   rmth_pkg::count_type    cnt_ff, cnt_in;
   logic                   rrej_ff, rrej_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr, ram_raddr;
   rmth_pkg::sample_type   ram_wdata, rdata_l, rdata_u, q;

   logic [AW+1:0]          lw, rw, nsel;
   logic [AW-1:0]          par;
   rmth_pkg::sample_type   cand;
   logic [AW-1:0]          cand_idx;
   logic                   fin, to_lower;
   logic [SW:0]            total;
   rmth_pkg::sample_type   mid;
   logic                   full;

   rmth_ram #(.WIDTH(32), .DEPTH(HEAP_DEPTH)) u_lower (
      .clock (clock), .we (ram_we && !sel_ff), .waddr (ram_waddr),
      .wdata (ram_wdata), .raddr (ram_raddr), .rdata (rdata_l)
   );

   rmth_ram #(.WIDTH(32), .DEPTH(HEAP_DEPTH)) u_upper (
      .clock (clock), .we (ram_we && sel_ff), .waddr (ram_waddr),
      .wdata (ram_wdata), .raddr (ram_raddr), .rdata (rdata_u)
   );

   assign q    = sel_ff ? rdata_u : rdata_l;
   assign lw   = {1'b0, idx_ff, 1'b1};
   assign rw   = lw + (AW+2)'(1);
   assign nsel = (AW+2)'(sel_ff ? us_ff : ls_ff);
   assign par  = AW'((idx_ff - AW'(1)) >> 1);
   assign full = (ls_ff == SW'(HEAP_DEPTH)) && (us_ff == SW'(HEAP_DEPTH));

   assign total = (SW+1)'(ls_ff) + (SW+1)'(us_ff);
   assign mid   = (ls_ff > us_ff) ? ltop_ff : utop_ff;

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      val_in        = val_ff;
      mov_in        = mov_ff;
      push_after_in = push_after_ff;
      idx_in        = idx_ff;
      lval_in       = lval_ff;
      rok_in        = rok_ff;
      ls_in         = ls_ff;
      us_in         = us_ff;
      rej_in        = rej_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      med_in        = med_ff;
      cnt_in        = cnt_ff;
      rrej_in       = rrej_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = val_ff;
      ram_raddr     = AW'(lw);
      fin           = 1'b0;
      cand          = lval_ff;
      cand_idx      = AW'(lw);
      to_lower      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rej_in        = 1'b0;
               push_after_in = 1'b0;
               val_in        = req_sample;
               idx_in        = '0;
               if (full) begin
                  rej_in   = 1'b1;
                  state_in = S_DONE;
               end else if (ls_ff == '0) begin
                  sel_in   = 1'b0;
                  idx_in   = AW'(ls_ff);
                  ls_in    = ls_ff + SW'(1);
                  state_in = S_UP_P;
               end else if (us_ff == '0) begin
                  if (req_sample >= ltop_ff) begin
                     sel_in   = 1'b1;
                     idx_in   = AW'(us_ff);
                     us_in    = us_ff + SW'(1);
                     state_in = S_UP_P;
                  end else begin
                     sel_in        = 1'b0;
                     mov_in        = ltop_ff;
                     push_after_in = 1'b1;
                     state_in      = S_DN_L;
                  end
               end else begin
                  if (req_sample < ltop_ff) to_lower = 1'b1;
                  else if (req_sample > utop_ff) to_lower = 1'b0;
                  else to_lower = !(ls_ff > us_ff);
                  if (to_lower && ls_ff > us_ff) begin
                     sel_in        = 1'b0;
                     mov_in        = ltop_ff;
                     push_after_in = 1'b1;
                     state_in      = S_DN_L;
                  end else if (to_lower) begin
                     sel_in   = 1'b0;
                     idx_in   = AW'(ls_ff);
                     ls_in    = ls_ff + SW'(1);
                     state_in = S_UP_P;
                  end else if (us_ff > ls_ff) begin
                     sel_in        = 1'b1;
                     mov_in        = utop_ff;
                     push_after_in = 1'b1;
                     state_in      = S_DN_L;
                  end else begin
                     sel_in   = 1'b1;
                     idx_in   = AW'(us_ff);
                     us_in    = us_ff + SW'(1);
                     state_in = S_UP_P;
                  end
               end
            end
         end
         S_DN_L: begin
            if (lw < nsel) begin
               ram_raddr = AW'(lw);
               state_in  = S_DN_R;
            end else begin
               ram_we = 1'b1;
               fin    = 1'b1;
            end
         end
         S_DN_R: begin
            lval_in   = q;
            rok_in    = rw < nsel;
            ram_raddr = AW'(rw);
            state_in  = S_DN_C;
         end
         S_DN_C: begin
            if (rok_ff && rmth_pkg::precedes(q, lval_ff, !sel_ff)) begin
               cand     = q;
               cand_idx = AW'(rw);
            end
            ram_we = 1'b1;
            if (rmth_pkg::precedes(cand, val_ff, !sel_ff)) begin
               ram_wdata = cand;
               idx_in    = cand_idx;
               state_in  = S_DN_L;
            end else begin
               fin = 1'b1;
            end
         end
         S_UP_P: begin
            if (idx_ff == '0) begin
               ram_we = 1'b1;
               fin    = 1'b1;
            end else begin
               ram_raddr = par;
               state_in  = S_UP_C;
            end
         end
         S_UP_C: begin
            ram_we = 1'b1;
            if (rmth_pkg::precedes(val_ff, q, !sel_ff)) begin
               ram_wdata = q;
               idx_in    = par;
               state_in  = S_UP_P;
            end else begin
               fin = 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (total[0]) begin
                  med_in = {mid[31], mid} <<< 1;
               end else begin
                  med_in = {ltop_ff[31], ltop_ff} + {utop_ff[31], utop_ff};
               end
               cnt_in   = rmth_pkg::COUNT_W'(total);
               rrej_in  = rej_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         if (push_after_ff) begin
            push_after_in = 1'b0;
            sel_in        = !sel_ff;
            val_in        = mov_ff;
            state_in      = S_UP_P;
            if (sel_ff) begin
               idx_in = AW'(ls_ff);
               ls_in  = ls_ff + SW'(1);
            end else begin
               idx_in = AW'(us_ff);
               us_in  = us_ff + SW'(1);
            end
         end else begin
            state_in = S_DONE;
         end
      end
   end

   // cached heap tops follow every write to the root
   always_comb begin
      ltop_in = ltop_ff;
      utop_in = utop_ff;
      if (ram_we && ram_waddr == '0) begin
         if (sel_ff) utop_in = ram_wdata;
         else        ltop_in = ram_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ls_ff        <= '0;
         us_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         push_after_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ls_ff        <= ls_in;
         us_ff        <= us_in;
         rsp_valid_ff <= rsp_valid_in;
         push_after_ff <= push_after_in;
      end
      sel_ff  <= sel_in;
      val_ff  <= val_in;
      mov_ff  <= mov_in;
      idx_ff  <= idx_in;
      lval_ff <= lval_in;
      rok_ff  <= rok_in;
      ltop_ff <= ltop_in;
      utop_ff <= utop_in;
      rej_ff  <= rej_in;
      med_ff  <= med_in;
      cnt_ff  <= cnt_in;
      rrej_ff <= rrej_in;
   end

   assign req_stall          = state_ff != S_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = med_ff;
   assign rsp_sample_count   = cnt_ff;
   assign rsp_rejected       = rrej_ff;

   a_balanced: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> (ls_ff == us_ff || ls_ff == us_ff + SW'(1) ||
                              us_ff == ls_ff + SW'(1)))
      else $error("heap sizes out of balance");

   a_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && us_ff != '0) |-> ltop_ff <= utop_ff)
      else $error("lower top above upper top");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rrej_ff) |-> full)
      else $error("item rejected with room left");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives a stream of signed samples into the two-heap running median and
// checks every result against a behavioural two-heap model kept here, with
// random idling on both sides, a drain pause, and rejection once full.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DEPTH      = 512;
   localparam int N_RANDOM   = 2000;
   localparam int PAUSE_AT   = 700;
   localparam int MAX_CYCLES = 1000000;
   localparam int TAIL       = 60;

   typedef struct packed {
      rmth_pkg::median_type med;
      rmth_pkg::count_type  cnt;
      logic                 rej;
   } median_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rmth_pkg::sample_type req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rmth_pkg::median_type rsp_median_doubled;
   rmth_pkg::count_type rsp_sample_count;
   logic rsp_rejected;

   rmth_pkg::sample_type pending_samples[$];
   median_result_type expected_medians[$];
   rmth_pkg::sample_type heap_mem[2][DEPTH];
   int heap_n[2];
   int n_sent, n_checked, n_rejected, n_errors, cycles;

   running_median_two_heaps_top #(.HEAP_DEPTH(DEPTH)) DUT (.*);

   always #2 clock = ~clock;

   function automatic logic ahead(int side, rmth_pkg::sample_type a,
                                  rmth_pkg::sample_type b);
      return side == 0 ? (a > b) : (a < b);
   endfunction

   task automatic heap_push(int side, rmth_pkg::sample_type v);
      int i, p;
      rmth_pkg::sample_type t;
      i = heap_n[side];
      heap_mem[side][i] = v;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!ahead(side, heap_mem[side][i], heap_mem[side][p])) break;
         t = heap_mem[side][i];
         heap_mem[side][i] = heap_mem[side][p];
         heap_mem[side][p] = t;
         i = p;
      end
      heap_n[side]++;
   endtask

   task automatic heap_swap_top(int side, rmth_pkg::sample_type v,
                                output rmth_pkg::sample_type old);
      int i, l, r, b;
      rmth_pkg::sample_type t;
      old = heap_mem[side][0];
      heap_mem[side][0] = v;
      i = 0;
      forever begin
         l = 2 * i + 1;
         r = l + 1;
         b = i;
         if (l < heap_n[side] && ahead(side, heap_mem[side][l], heap_mem[side][b])) b = l;
         if (r < heap_n[side] && ahead(side, heap_mem[side][r], heap_mem[side][b])) b = r;
         if (b == i) break;
         t = heap_mem[side][i];
         heap_mem[side][i] = heap_mem[side][b];
         heap_mem[side][b] = t;
         i = b;
      end
   endtask

   task automatic add_sample(rmth_pkg::sample_type x);
      rmth_pkg::sample_type m;
      logic to_lo;
      if (heap_n[0] == 0) begin
         heap_push(0, x);
      end else if (heap_n[1] == 0) begin
         if (x >= heap_mem[0][0]) begin
            heap_push(1, x);
         end else begin
            heap_swap_top(0, x, m);
            heap_push(1, m);
         end
      end else begin
         if (x < heap_mem[0][0]) to_lo = 1'b1;
         else if (x > heap_mem[1][0]) to_lo = 1'b0;
         else to_lo = !(heap_n[0] > heap_n[1]);
         if (to_lo) begin
            if (heap_n[0] > heap_n[1]) begin
               heap_swap_top(0, x, m);
               heap_push(1, m);
            end else begin
               heap_push(0, x);
            end
         end else begin
            if (heap_n[1] > heap_n[0]) begin
               heap_swap_top(1, x, m);
               heap_push(0, m);
            end else begin
               heap_push(1, x);
            end
         end
      end
   endtask

   task automatic predict_median(rmth_pkg::sample_type x);
      median_result_type e;
      rmth_pkg::sample_type mid;
      int total;
      e.rej = (heap_n[0] >= DEPTH && heap_n[1] >= DEPTH);
      if (!e.rej) add_sample(x);
      total = heap_n[0] + heap_n[1];
      if (total % 2 == 1) begin
         mid = heap_n[0] > heap_n[1] ? heap_mem[0][0] : heap_mem[1][0];
         e.med = {mid, 1'b0};
      end else begin
         e.med = {heap_mem[0][0][31], heap_mem[0][0]} + {heap_mem[1][0][31], heap_mem[1][0]};
      end
      e.cnt = total[10:0];
      expected_medians.push_back(e);
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s at result %0d: got %0h want %0h", what, n_checked, got, want);
      n_errors++;
   endtask

   function automatic int phase();
      return n_sent < (N_RANDOM / 3) ? 0 : (n_sent < (2 * N_RANDOM / 3) ? 1 : 2);
   endfunction

   function automatic logic idle_now(int pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   always @(posedge clock) begin
      int ph;
      logic go;
      ph = phase();
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
         req_valid <= 1'b1;
      end else begin
         if (req_valid) begin
            predict_median(req_sample);
            void'(pending_samples.pop_front());
            n_sent++;
         end
         go = pending_samples.size() > 0
              && !(ph == 0 && idle_now(29)) && !(ph == 1 && idle_now(71))
              && !(n_sent == PAUSE_AT && expected_medians.size() > 0);
         req_valid <= go;
         if (go) req_sample <= pending_samples[0];
      end
   end

   always @(posedge clock) begin
      median_result_type e;
      int ph;
      ph = phase();
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_medians.size() == 0) begin
               report("unexpected item", rsp_median_doubled, 0);
            end else begin
               e = expected_medians.pop_front();
               if (rsp_median_doubled !== e.med) report("median", rsp_median_doubled, e.med);
               if (rsp_sample_count !== e.cnt) report("count", rsp_sample_count, e.cnt);
               if (rsp_rejected !== e.rej) report("rejected", rsp_rejected, e.rej);
               if (e.rej) n_rejected++;
            end
            n_checked++;
         end
         rsp_stall <= (ph == 0 && idle_now(71)) || (ph == 1 && idle_now(29));
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > MAX_CYCLES) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      rmth_pkg::sample_type directed[$];
      int pick;
      directed = '{32'sd5, -32'sd3, 32'sd5, 32'sd5, 32'sh7fffffff, 32'sh80000000,
                   32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, 32'sd1, 32'sd4,
                   32'sd4, 32'sd3, 32'sd6, 32'sd2, 32'sh7ffffffe, 32'sh80000001,
                   32'sd0, 32'sd0};
      foreach (directed[i]) pending_samples.push_back(directed[i]);
      for (int i = 0; i < N_RANDOM; i++) begin
         pick = $urandom_range(9, 0);
         if (pick < 4) pending_samples.push_back($urandom);
         else if (pick < 8) pending_samples.push_back($signed($urandom_range(20, 0)) - 10);
         else if (pick == 8) pending_samples.push_back(32'sh7fffffff - $urandom_range(3, 0));
         else pending_samples.push_back(32'sh80000000 + $urandom_range(3, 0));
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_samples.size() == 0);
      while (expected_medians.size() > 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
      if (expected_medians.size() > 0) begin
         $display("leftover expectations: %0d", expected_medians.size());
         n_errors++;
      end
      $display("sent %0d samples, checked %0d results, %0d rejected when full",
               n_sent, n_checked, n_rejected);
      if (n_errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule

// ===== running_median_two_heaps_top.f =====
rtl/rmth_pkg.sv
rtl/rmth_ram.sv
rtl/running_median_two_heaps_top.sv
test/tb_top.sv
